// ----- design/rhcc_pkg.sv -----
// Shared types and constants for the RGB565 HSV color classifier.
// Has no dependencies. The front end, the classify stage and the top level use it.
package rhcc_pkg;

  localparam int DIV_STAGES = 8;
  localparam int HUE_BITS   = 6;
  localparam int LATENCY    = DIV_STAGES + 3;

  localparam logic [7:0] HUE_BASE_RED   = 8'd0;
  localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
  localparam logic [13:0] HUE_SCALE     = 14'd43;

  localparam logic [7:0] RED_HUE_LO    = 8'd10;
  localparam logic [7:0] RED_HUE_HI    = 8'd225;
  localparam logic [7:0] GREEN_HUE_LO  = 8'd55;
  localparam logic [7:0] GREEN_HUE_HI  = 8'd120;
  localparam logic [7:0] GREEN_SAT_MIN = 8'd25;
  localparam logic [7:0] GREEN_VAL_MIN = 8'd25;
  localparam logic [7:0] BLUE_HUE_LO   = 8'd120;
  localparam logic [7:0] BLUE_HUE_HI   = 8'd165;
  localparam logic [7:0] BLUE_SAT_MIN  = 8'd35;
  localparam logic [7:0] VAL_MIN       = 8'd30;
  localparam logic [7:0] VAL_MAX       = 8'd250;
  localparam logic [7:0] YEL_HUE_LO    = 8'd25;
  localparam logic [7:0] YEL_HUE_HI    = 8'd55;
  localparam logic [7:0] YEL_SAT_MIN   = 8'd50;
  localparam logic [7:0] ORANGE_HUE_HI = 8'd15;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_e;

  typedef enum logic [2:0] {
    CLS_BLACK,
    CLS_RED,
    CLS_GREEN,
    CLS_BLUE,
    CLS_YELLOW,
    CLS_ORANGE,
    CLS_NONE
  } cls_e;

  typedef struct packed {
    logic [15:0]         s_rem;
    logic [7:0]          v;
    logic [7:0]          s_quo;
    logic [13:0]         h_rem;
    logic [7:0]          d;
    logic [HUE_BITS-1:0] h_quo;
    logic                neg;
    sect_e               sect;
    logic                zero;
    logic                black;
  } div_t;

endpackage

// ----- design/rgb565_hsv_color_classifier.sv -----
// Top level of the RGB565 to HSV color classifier: front end, divider pipeline, output stage.
// Depends on rhcc_pkg, rhcc_front and rhcc_classify.
//
// Usage: drive pixel_i and raise start_i; the request is taken at a rising edge
// where start_i is high and busy_o is low. busy_o is high only right after
// reset and low from the first clock after reset, so one request can be taken
// every cycle.
// Each result appears on color_class_o, hue_o, saturation_o and brightness_o
// for exactly one cycle, marked by valid_o, once its request has passed through
// two front-end stages (widen, max/min, then dividends), eight restoring
// divider stages (one quotient bit each for saturation, and for hue in the
// last six), and one classify/output stage. Results leave in request order.
// Throughput is one pixel per clock; there is no stall path, and the
// receiver must take every result in the cycle it is shown.
// Reset clears all valid bits, so no result appears until a new request
// has passed through the pipeline.
module rgb565_hsv_color_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] pixel_i,
  output logic        valid_o,
  output logic [2:0]  color_class_o,
  output logic [7:0]  hue_o,
  output logic [7:0]  saturation_o,
  output logic [7:0]  brightness_o
);
  import rhcc_pkg::*;

  logic busy_q, busy_d;
  logic accept;

  logic front_valid;
  div_t front_div;

  div_t div_d [DIV_STAGES];
  div_t div_q [DIV_STAGES];
  logic vld_q [DIV_STAGES];

  assign busy_d = 1'b0;
  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
    end
  end

  rhcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pixel_i (pixel_i),
    .valid_o (front_valid),
    .div_o   (front_div)
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    localparam int K = DIV_STAGES - 1 - i;
    div_t cur;
    logic cur_vld;
    logic [15:0] s_trial;

    if (i == 0) begin : g_first
      assign cur     = front_div;
      assign cur_vld = front_valid;
    end else begin : g_next
      assign cur     = div_q[i-1];
      assign cur_vld = vld_q[i-1];
    end

    assign s_trial = 16'({8'h00, cur.v} << K);

    if (K < HUE_BITS) begin : g_hue
      logic [13:0] h_trial;
      assign h_trial = 14'({6'h00, cur.d} << K);
      always_comb begin
        div_d[i] = cur;
        if (cur.s_rem >= s_trial) begin
          div_d[i].s_rem    = cur.s_rem - s_trial;
          div_d[i].s_quo[K] = 1'b1;
        end
        if (cur.h_rem >= h_trial) begin
          div_d[i].h_rem    = cur.h_rem - h_trial;
          div_d[i].h_quo[K] = 1'b1;
        end
      end
    end else begin : g_sat
      always_comb begin
        div_d[i] = cur;
        if (cur.s_rem >= s_trial) begin
          div_d[i].s_rem    = cur.s_rem - s_trial;
          div_d[i].s_quo[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[i] <= div_d[i];
    end
  end

  rhcc_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vld_q[DIV_STAGES-1]),
    .div_i         (div_q[DIV_STAGES-1]),
    .valid_o       (valid_o),
    .color_class_o (color_class_o),
    .hue_o         (hue_o),
    .saturation_o  (saturation_o),
    .brightness_o  (brightness_o)
  );

  assign busy_o = busy_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(start_i, LATENCY) && !$past(busy_o, LATENCY)))
    else $error("result without a matching request");

  a_dark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o == 8'd0) |-> (saturation_o == 8'd0 && hue_o == 8'd0))
    else $error("zero brightness with nonzero hue or saturation");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturation_o == 8'd0) |-> (hue_o == 8'd0))
    else $error("zero saturation with nonzero hue");

  a_red_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hue_o <= RED_HUE_LO) |->
      (color_class_o == CLS_BLACK || color_class_o == CLS_RED))
    else $error("low hue not classified red or black");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o != 8'd0 && saturation_o == 8'd0) |->
      (color_class_o == CLS_BLACK || color_class_o == CLS_RED))
    else $error("grey pixel not classified red or black");

endmodule

// ----- design/rhcc_front.sv -----
// Front end: widen channels, find max/min and hue sector, black test, set up dividends.
// Two register stages. Depends on rhcc_pkg.
module rhcc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [15:0]   pixel_i,
  output logic          valid_o,
  output rhcc_pkg::div_t div_o
);
  import rhcc_pkg::*;

  logic [4:0] r5, b5, gh;
  logic [5:0] g6;
  logic [7:0] r8, g8, b8;
  logic [7:0] mx, mn, pa, pb;
  logic [4:0] ad_br, ad_gb, ad_rg;
  logic       black;
  sect_e      sect;

  logic       a_valid_q;
  logic [7:0] mx_q, mn_q, pa_q, pb_q;
  sect_e      sect_q;
  logic       black_q;

  logic [7:0] d, diff;
  logic       neg;
  div_t       div_d, div_q;
  logic       b_valid_q;

  always_comb begin
    r5 = pixel_i[15:11];
    g6 = pixel_i[10:5];
    b5 = pixel_i[4:0];
    gh = g6[5:1];
    r8 = {r5, r5[4:2]};
    g8 = {g6, g6[5:4]};
    b8 = {b5, b5[4:2]};

    mx = r8;
    if (g8 > mx) mx = g8;
    if (b8 > mx) mx = b8;
    mn = r8;
    if (g8 < mn) mn = g8;
    if (b8 < mn) mn = b8;

    if (r8 >= g8 && r8 >= b8) begin
      sect = SECT_RED;
      pa   = g8;
      pb   = b8;
    end else if (g8 >= b8) begin
      sect = SECT_GREEN;
      pa   = b8;
      pb   = r8;
    end else begin
      sect = SECT_BLUE;
      pa   = r8;
      pb   = g8;
    end

    ad_br = (b5 > r5) ? b5 - r5 : r5 - b5;
    ad_gb = (gh > b5) ? gh - b5 : b5 - gh;
    ad_rg = (r5 > gh) ? r5 - gh : gh - r5;
    black = (r5 < 5'd8) && (g6 < 6'd15) && (b5 < 5'd8) &&
            (ad_br <= 5'd2) && (ad_gb <= 5'd3) && (ad_rg <= 5'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= mx;
    mn_q    <= mn;
    pa_q    <= pa;
    pb_q    <= pb;
    sect_q  <= sect;
    black_q <= black;
    div_q   <= div_d;
  end

  always_comb begin
    d    = mx_q - mn_q;
    neg  = pa_q < pb_q;
    diff = neg ? pb_q - pa_q : pa_q - pb_q;

    div_d       = '0;
    div_d.s_rem = {d, 8'h00} - {8'h00, d};
    div_d.v     = mx_q;
    div_d.h_rem = 14'(diff) * HUE_SCALE;
    div_d.d     = d;
    div_d.neg   = neg;
    div_d.sect  = sect_q;
    div_d.zero  = (d == 8'd0);
    div_d.black = black_q;
  end

  assign valid_o = b_valid_q;
  assign div_o   = div_q;

endmodule

// ----- design/rhcc_classify.sv -----
// Output stage: assemble hue and saturation, run the priority class tests, register result.
// Depends on rhcc_pkg.
module rhcc_classify (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rhcc_pkg::div_t div_i,
  output logic           valid_o,
  output logic [2:0]     color_class_o,
  output logic [7:0]     hue_o,
  output logic [7:0]     saturation_o,
  output logic [7:0]     brightness_o
);
  import rhcc_pkg::*;

  logic [7:0] base, mag, h, s, v;
  cls_e       cls;

  logic       valid_q;
  cls_e       cls_q;
  logic [7:0] h_q, s_q, v_q;

  always_comb begin
    case (div_i.sect)
      SECT_RED:   base = HUE_BASE_RED;
      SECT_GREEN: base = HUE_BASE_GREEN;
      SECT_BLUE:  base = HUE_BASE_BLUE;
      default:    base = HUE_BASE_RED;
    endcase
    mag = {{(8 - HUE_BITS){1'b0}}, div_i.h_quo};
    v   = div_i.v;
    if (div_i.zero) begin
      h = 8'd0;
      s = 8'd0;
    end else begin
      h = div_i.neg ? base - mag : base + mag;
      s = div_i.s_quo;
    end

    if (div_i.black)
      cls = CLS_BLACK;
    else if (h <= RED_HUE_LO || h >= RED_HUE_HI)
      cls = CLS_RED;
    else if (h >= GREEN_HUE_LO && h <= GREEN_HUE_HI && s >= GREEN_SAT_MIN &&
             v >= GREEN_VAL_MIN)
      cls = CLS_GREEN;
    else if (h >= BLUE_HUE_LO && h <= BLUE_HUE_HI && s >= BLUE_SAT_MIN &&
             v >= VAL_MIN && v <= VAL_MAX)
      cls = CLS_BLUE;
    else if (h >= YEL_HUE_LO && h <= YEL_HUE_HI && s >= YEL_SAT_MIN &&
             v >= VAL_MIN && v <= VAL_MAX)
      cls = CLS_YELLOW;
    else if (h <= ORANGE_HUE_HI)
      cls = CLS_ORANGE;
    else
      cls = CLS_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls;
    h_q   <= h;
    s_q   <= s;
    v_q   <= v;
  end

  assign valid_o       = valid_q;
  assign color_class_o = cls_q;
  assign hue_o         = h_q;
  assign saturation_o  = s_q;
  assign brightness_o  = v_q;

endmodule
